/* rtl/wual_pkg.sv */
// shared types and constants of the antialiased line walker
`default_nettype none
package wual_pkg;

   localparam int COORD_WIDTH     = 5;
   localparam int PIXEL_X_WIDTH   = 7;
   localparam int PIXEL_Y_WIDTH   = 6;
   localparam int SHADE_WIDTH     = 4;
   localparam int ACC_WIDTH       = 32;
   localparam int SHADE_SHIFT     = 28;
   localparam int REQ_TDATA_WIDTH = 24;
   localparam int RSP_TDATA_WIDTH = 24;

   localparam int SCREEN_WIDTH_DEFAULT  = 32;
   localparam int SCREEN_HEIGHT_DEFAULT = 32;
   localparam int SHADE_LEVELS          = 16;

   localparam logic [SHADE_WIDTH-1:0] SHADE_FULL = SHADE_WIDTH'(SHADE_LEVELS - 1);

   typedef enum logic [2:0] {
      LM_IDLE,
      LM_HORIZ,
      LM_VERT,
      LM_DIAG,
      LM_YMAJOR,
      LM_XMAJOR
   } line_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FIRST,
      ST_RUN,
      ST_MAIN,
      ST_NEIGH,
      ST_END
   } walk_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic signed [PIXEL_X_WIDTH-1:0] x;
      logic [PIXEL_Y_WIDTH-1:0]        y;
      logic [SHADE_WIDTH-1:0]          shade;
      logic                            last;
   } pixel_type;

endpackage
`default_nettype wire

/* rtl/wu_antialiased_line_walker_core.sv */
// antialiased line walker: top level with the walk sequencer
//
// req channel takes one line command: two endpoints of 5-bit column and row.
// rsp channel returns the pixels of that line, one item each, with column,
// row, 4-bit shade index, a visible flag in tuser and tlast on the final
// pixel. a line of n pixels gives n items: horizontal, vertical and diagonal
// lines dx+1 or dy+1, other lines twice the major length.
// req_tready is high only while the walker is idle; one command is worked
// at a time.
// sequence per command: the accept, then for lines that are neither
// straight nor diagonal a run of the bit-serial divider that forms the
// error step, then the pixels, the error summed in the 32-bit accumulator.
// each pixel passes through the output register before it appears on rsp;
// a stalled rsp_tready holds the register and the walk waits.
// synchronous reset returns the walker to idle and empties the output
// register; no pixel survives reset.
`default_nettype none
module wu_antialiased_line_walker_core #(
   parameter int SCREEN_WIDTH  = wual_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = wual_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   input  wire logic [wual_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,  // x_start, y_start, x_end, y_end
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output      logic [wual_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,  // pixel_x, pixel_y, shade_index
   output      logic                                  rsp_tuser,  // visible
   output      logic                                  rsp_tlast
);

   localparam int CW = wual_pkg::COORD_WIDTH;
   localparam int XW = wual_pkg::PIXEL_X_WIDTH;
   localparam int YW = wual_pkg::PIXEL_Y_WIDTH;
   localparam int AW = wual_pkg::ACC_WIDTH;
   localparam int SW = wual_pkg::SHADE_WIDTH;
   localparam int SS = wual_pkg::SHADE_SHIFT;

   wual_pkg::walk_state_type state_ff, state_in;
   wual_pkg::line_mode_type  mode_ff, mode_in;
   logic signed [XW-1:0]     cursor_x_ff, cursor_x_in;
   logic [YW-1:0]            cursor_y_ff, cursor_y_in;
   logic [AW-1:0]            acc_ff, acc_in;
   logic [AW-1:0]            step_ff, step_in;
   logic [CW-1:0]            steps_left_ff, steps_left_in;
   logic                     dir_ff, dir_in;
   logic [CW-1:0]            end_x_ff, end_x_in;
   logic [CW-1:0]            end_y_ff, end_y_in;

   // command decode
   logic [CW-1:0]            x_start, y_start, x_end, y_end;
   logic [CW-1:0]            sx0, sy0, sx1, sy1;
   logic [CW:0]              dx_signed;
   logic [CW-1:0]            adx, ady;
   logic                     dx_neg;
   wual_pkg::line_mode_type  mode_dec;
   logic                     wu_dec;
   logic [CW-1:0]            major_dec, minor_dec;

   logic                     req_fire;
   logic                     div_start;
   wual_pkg::div_status_type div_status;
   logic [AW-1:0]            div_quotient;

   logic                     emit;
   logic                     can_load;
   wual_pkg::pixel_type      pixel;
   logic signed [XW-1:0]     dir_delta;
   logic signed [XW-1:0]     x_stepped;
   logic [YW-1:0]            y_stepped;
   logic [AW:0]              acc_sum;
   logic                     carry;
   logic                     ymajor;

   assign x_start = req_tdata[CW-1:0];
   assign y_start = req_tdata[2*CW-1:CW];
   assign x_end   = req_tdata[3*CW-1:2*CW];
   assign y_end   = req_tdata[4*CW-1:3*CW];

   assign req_tready = (state_ff == wual_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      // endpoints are ordered so the line runs downward
      if (y_start > y_end) begin
         sx0 = x_end;
         sy0 = y_end;
         sx1 = x_start;
         sy1 = y_start;
      end else begin
         sx0 = x_start;
         sy0 = y_start;
         sx1 = x_end;
         sy1 = y_end;
      end
      dx_signed = {1'b0, sx1} - {1'b0, sx0};
      dx_neg    = dx_signed[CW];
      adx       = dx_neg ? CW'(-dx_signed) : dx_signed[CW-1:0];
      ady       = sy1 - sy0;
      if (ady == '0) begin
         mode_dec = wual_pkg::LM_HORIZ;
      end else if (adx == '0) begin
         mode_dec = wual_pkg::LM_VERT;
      end else if (adx == ady) begin
         mode_dec = wual_pkg::LM_DIAG;
      end else if (ady > adx) begin
         mode_dec = wual_pkg::LM_YMAJOR;
      end else begin
         mode_dec = wual_pkg::LM_XMAJOR;
      end
      wu_dec    = (mode_dec == wual_pkg::LM_YMAJOR) || (mode_dec == wual_pkg::LM_XMAJOR);
      major_dec = (mode_dec == wual_pkg::LM_YMAJOR) ? ady : adx;
      minor_dec = (mode_dec == wual_pkg::LM_YMAJOR) ? adx : ady;
   end

   assign div_start = req_fire && wu_dec;

   wual_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .minor    (minor_dec),
      .major    (major_dec),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // shared step arithmetic
   always_comb begin
      dir_delta = dir_ff ? -XW'(1) : XW'(1);
      x_stepped = cursor_x_ff + dir_delta;
      y_stepped = cursor_y_ff + 1'b1;
      acc_sum   = {1'b0, acc_ff} + {1'b0, step_ff};
      carry     = acc_sum[AW];
      ymajor    = (mode_ff == wual_pkg::LM_YMAJOR);
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      steps_left_in = steps_left_ff;
      dir_in        = dir_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      emit          = 1'b0;
      pixel.x       = cursor_x_ff;
      pixel.y       = cursor_y_ff;
      pixel.shade   = wual_pkg::SHADE_FULL;
      pixel.last    = 1'b0;
      case (state_ff)
         wual_pkg::ST_IDLE: begin
            if (req_fire) begin
               mode_in       = mode_dec;
               dir_in        = dx_neg;
               cursor_x_in   = XW'(sx0);
               cursor_y_in   = YW'(sy0);
               end_x_in      = sx1;
               end_y_in      = sy1;
               acc_in        = '0;
               step_in       = '0;
               if (wu_dec) begin
                  steps_left_in = major_dec - 1'b1;
                  state_in      = wual_pkg::ST_DIVIDE;
               end else begin
                  steps_left_in = (mode_dec == wual_pkg::LM_HORIZ) ? adx : ady;
                  state_in      = wual_pkg::ST_FIRST;
               end
            end
         end
         wual_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               step_in  = div_quotient;
               state_in = wual_pkg::ST_FIRST;
            end
         end
         wual_pkg::ST_FIRST: begin
            emit       = 1'b1;
            pixel.last = (mode_ff == wual_pkg::LM_HORIZ) && (steps_left_ff == '0);
            if (can_load) begin
               if ((mode_ff == wual_pkg::LM_YMAJOR) || (mode_ff == wual_pkg::LM_XMAJOR)) begin
                  state_in = (steps_left_ff == '0) ? wual_pkg::ST_END : wual_pkg::ST_MAIN;
               end else begin
                  state_in = (steps_left_ff == '0) ? wual_pkg::ST_IDLE : wual_pkg::ST_RUN;
               end
            end
         end
         wual_pkg::ST_RUN: begin
            emit = 1'b1;
            if (mode_ff != wual_pkg::LM_VERT) begin
               pixel.x = x_stepped;
            end
            if (mode_ff != wual_pkg::LM_HORIZ) begin
               pixel.y = y_stepped;
            end
            pixel.last = (steps_left_ff == CW'(1));
            if (can_load) begin
               cursor_x_in   = pixel.x;
               cursor_y_in   = pixel.y;
               steps_left_in = steps_left_ff - 1'b1;
               if (steps_left_ff == CW'(1)) begin
                  state_in = wual_pkg::ST_IDLE;
               end
            end
         end
         wual_pkg::ST_MAIN: begin
            emit = 1'b1;
            // wraparound of the accumulator moves the minor axis
            if (ymajor) begin
               pixel.x = carry ? x_stepped : cursor_x_ff;
               pixel.y = y_stepped;
            end else begin
               pixel.x = x_stepped;
               pixel.y = carry ? y_stepped : cursor_y_ff;
            end
            pixel.shade = acc_sum[SS+SW-1:SS] ^ wual_pkg::SHADE_FULL;
            if (can_load) begin
               cursor_x_in   = pixel.x;
               cursor_y_in   = pixel.y;
               acc_in        = acc_sum[AW-1:0];
               steps_left_in = steps_left_ff - 1'b1;
               state_in      = wual_pkg::ST_NEIGH;
            end
         end
         wual_pkg::ST_NEIGH: begin
            emit = 1'b1;
            if (ymajor) begin
               pixel.x = x_stepped;
            end else begin
               pixel.y = y_stepped;
            end
            pixel.shade = acc_ff[SS+SW-1:SS];
            if (can_load) begin
               state_in = (steps_left_ff == '0) ? wual_pkg::ST_END : wual_pkg::ST_MAIN;
            end
         end
         wual_pkg::ST_END: begin
            emit       = 1'b1;
            pixel.x    = XW'(end_x_ff);
            pixel.y    = YW'(end_y_ff);
            pixel.last = 1'b1;
            if (can_load) begin
               cursor_x_in = XW'(end_x_ff);
               cursor_y_in = YW'(end_y_ff);
               state_in    = wual_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wual_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wual_pkg::ST_IDLE;
         mode_ff       <= wual_pkg::LM_IDLE;
         steps_left_ff <= '0;
         dir_ff        <= 1'b0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         acc_ff        <= '0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         steps_left_ff <= steps_left_in;
         dir_ff        <= dir_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         acc_ff        <= acc_in;
         step_ff       <= step_in;
      end
      end_x_ff <= end_x_in;
      end_y_ff <= end_y_in;
   end

   wual_pixel_out #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_pixel_out (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .pixel      (pixel),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // a taken command holds off the next one; ready is low in the cycle after
   assert property (@(posedge clock) disable iff (reset) req_fire |=> !req_tready)
      else $error("walker ready right after taking a command");

   // endpoints of a line always carry full shade
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[XW+YW+SW-1:XW+YW] == wual_pkg::SHADE_FULL))
      else $error("last pixel without full shade");

   // a visible pixel never has a negative column
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tdata[XW-1])
      else $error("visible pixel left of screen");

   // waiting on the divider only while it runs or has just finished
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == wual_pkg::ST_DIVIDE) |-> (div_status.busy || div_status.done))
      else $error("divide wait with idle divider");
`endif

endmodule
`default_nettype wire

/* rtl/wual_divider.sv */
// bit-serial restoring divider for the error step, (minor << 32) / major
`default_nettype none
module wual_divider (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [wual_pkg::COORD_WIDTH-1:0]      minor,
   input  wire logic [wual_pkg::COORD_WIDTH-1:0]      major,
   output      wual_pkg::div_status_type              status,
   output      logic [wual_pkg::ACC_WIDTH-1:0]        quotient
);

   localparam int CW = wual_pkg::COORD_WIDTH;
   localparam int QW = wual_pkg::ACC_WIDTH;
   localparam int NW = $clog2(QW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] count_ff, count_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] divisor_ff, divisor_in;
   logic [QW-1:0] quot_ff, quot_in;

   logic [CW:0]   shifted;
   logic [CW:0]   diff;
   logic          ge;

   always_comb begin
      shifted    = {rem_ff, 1'b0};
      diff       = shifted - {1'b0, divisor_ff};
      ge         = shifted >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = NW'(QW - 1);
         rem_in     = minor;
         divisor_in = major;
         quot_in    = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the coordinate width
         rem_in   = ge ? diff[CW-1:0] : shifted[CW-1:0];
         quot_in  = {quot_ff[QW-2:0], ge};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule
`default_nettype wire

/* rtl/wual_pixel_out.sv */
// output register for pixel items with the visibility check
`default_nettype none
module wual_pixel_out #(
   parameter int SCREEN_WIDTH  = wual_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = wual_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    load,
   input  wire wual_pkg::pixel_type                     pixel,
   output      logic                                    can_load,
   output      logic                                    rsp_tvalid,
   input  wire logic                                    rsp_tready,
   output      logic [wual_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,  // pixel_x, pixel_y, shade_index
   output      logic                                    rsp_tuser,  // visible
   output      logic                                    rsp_tlast
);

   localparam int XW = wual_pkg::PIXEL_X_WIDTH;
   localparam int YW = wual_pkg::PIXEL_Y_WIDTH;
   localparam int SW = wual_pkg::SHADE_WIDTH;
   localparam int DW = wual_pkg::RSP_TDATA_WIDTH;
   localparam logic signed [XW-1:0] X_LIMIT = XW'(SCREEN_WIDTH);
   localparam logic [YW-1:0]        Y_LIMIT = YW'(SCREEN_HEIGHT);

   logic                valid_ff, valid_in;
   wual_pkg::pixel_type pix_ff, pix_in;
   logic                vis_ff, vis_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      pix_in   = pix_ff;
      vis_in   = vis_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load && can_load) begin
         valid_in = 1'b1;
         pix_in   = pixel;
         vis_in   = !pixel.x[XW-1] && (pixel.x < X_LIMIT) && (pixel.y < Y_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pix_ff <= pix_in;
      vis_ff <= vis_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(DW - XW - YW - SW)'(0), pix_ff.shade, pix_ff.y, pix_ff.x};
   assign rsp_tuser  = vis_ff;
   assign rsp_tlast  = pix_ff.last;

endmodule
`default_nettype wire
